>>> rtl/core/wdr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wdr_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ============================================================================
package wdr_pkg;

    localparam int ANGLE_FRAC_BITS_DEFAULT = 16;

    // Q4.30 trig datapath width and rotation step count
    localparam int TRIG_W       = 34;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 2 * HALF_PI_Q30;
    localparam longint TWO_PI_Q30  = 4 * HALF_PI_Q30;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    // Reset values of registers and pose
    localparam logic        [31:0] MPC_RESET     = 32'd193625;
    localparam logic signed [19:0] OFFSET_RESET  = 20'sd102944;
    localparam logic signed [19:0] HEADING_RESET = 20'sd102944;
    localparam logic signed [31:0] START_X_RESET = 32'sd622592;
    localparam logic signed [31:0] START_Y_RESET = -32'sd707789;

    typedef enum logic [1:0] {
        REG_MPC     = 2'd0,
        REG_OFFSET  = 2'd1,
        REG_START_X = 2'd2,
        REG_START_Y = 2'd3
    } wdr_reg_idx_t;

    localparam logic FUNC_ENCODER = 1'b0;
    localparam logic FUNC_HEADING = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIST,
        S_WAIT,
        S_DISP_X,
        S_DISP_Y,
        S_UPD_Y,
        S_FINISH
    } wdr_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_SIGN,
        CS_WRAP,
        CS_HALF,
        CS_ROTATE,
        CS_OUT
    } wdr_cs_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } wdr_trig_t;

    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [STEP_W-1:0] step);
        logic signed [TRIG_W-1:0] a;
        case (step)
            5'd0:    a = 34'sh3243F6A8;
            5'd1:    a = 34'sh1DAC6705;
            5'd2:    a = 34'sh0FADBAFC;
            5'd3:    a = 34'sh07F56EA6;
            5'd4:    a = 34'sh03FEAB76;
            5'd5:    a = 34'sh01FFD55B;
            5'd6:    a = 34'sh00FFFAAA;
            5'd7:    a = 34'sh007FFF55;
            5'd8:    a = 34'sh003FFFEA;
            5'd9:    a = 34'sh001FFFFD;
            5'd10:   a = 34'sh000FFFFF;
            5'd11:   a = 34'sh0007FFFF;
            5'd12:   a = 34'sh0003FFFF;
            5'd13:   a = 34'sh0001FFFF;
            5'd14:   a = 34'sh0000FFFF;
            5'd15:   a = 34'sh00007FFF;
            5'd16:   a = 34'sh00003FFF;
            5'd17:   a = 34'sh00001FFF;
            5'd18:   a = 34'sh00000FFF;
            5'd19:   a = 34'sh000007FF;
            5'd20:   a = 34'sh000003FF;
            5'd21:   a = 34'sh000001FF;
            5'd22:   a = 34'sh000000FF;
            5'd23:   a = 34'sh0000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/wdr_sincos.sv
`timescale 1ns / 1ps
// ============================================================================
// wdr_sincos
// Iterative sine/cosine: modulo-2pi reduction, quadrant fold, 24-step CORDIC.
// ============================================================================
module wdr_sincos
    import wdr_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [19:0] theta,
    output wdr_trig_t          trig
);

    localparam int REDUCE_STEPS = (17 - ANGLE_FRAC_BITS > 1) ? 17 - ANGLE_FRAC_BITS : 1;
    localparam int K_W          = (REDUCE_STEPS > 1) ? $clog2(REDUCE_STEPS) : 1;
    localparam int RED_W        = (50 - ANGLE_FRAC_BITS > TRIG_W) ?
                                  50 - ANGLE_FRAC_BITS : TRIG_W;
    localparam int ANGLE_SHIFT  = 30 - ANGLE_FRAC_BITS;

    localparam logic        [RED_W-1:0]  TWO_PI_R  = RED_W'(TWO_PI_Q30);
    localparam logic signed [TRIG_W-1:0] PI_Z      = TRIG_W'(PI_Q30);
    localparam logic signed [TRIG_W-1:0] HALF_PI_Z = TRIG_W'(HALF_PI_Q30);
    localparam logic signed [TRIG_W-1:0] TWO_PI_Z  = TRIG_W'(TWO_PI_Q30);
    localparam logic signed [TRIG_W-1:0] GAIN_Z    = TRIG_W'(CORDIC_GAIN);
    localparam logic        [K_W-1:0]    K_LAST    = K_W'(REDUCE_STEPS - 1);
    localparam logic        [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    wdr_cs_t                  cs_reg, cs_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [RED_W-1:0]         red_mag_reg, red_mag_next;
    logic                     red_neg_reg, red_neg_next;
    logic                     qneg_reg, qneg_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [TRIG_W-1:0] z_reg, z_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;
    logic                     done_reg, done_next;

    logic [19:0]              theta_mag;
    logic [RED_W-1:0]         red_sub;
    logic signed [TRIG_W-1:0] x_sh, y_sh;

    always_comb
    begin
        cs_next = cs_reg;
        case (cs_reg)
            CS_IDLE:   if (start) cs_next = CS_REDUCE;
            CS_REDUCE: if (k_reg == '0) cs_next = CS_SIGN;
            CS_SIGN:   cs_next = CS_WRAP;
            CS_WRAP:   cs_next = CS_HALF;
            CS_HALF:   cs_next = CS_ROTATE;
            CS_ROTATE: if (step_reg == STEP_LAST) cs_next = CS_OUT;
            CS_OUT:    cs_next = CS_IDLE;
            default:   cs_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        k_next       = k_reg;
        step_next    = step_reg;
        red_mag_next = red_mag_reg;
        red_neg_next = red_neg_reg;
        qneg_next    = qneg_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        cos_next     = cos_reg;
        sin_next     = sin_reg;
        done_next    = 1'b0;

        theta_mag = theta[19] ? 20'(-theta) : 20'(theta);
        red_sub   = TWO_PI_R << k_reg;
        x_sh      = x_reg >>> step_reg;
        y_sh      = y_reg >>> step_reg;

        case (cs_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    red_mag_next = RED_W'(theta_mag) << ANGLE_SHIFT;
                    red_neg_next = theta[19];
                    k_next       = K_LAST;
                end
            end
            CS_REDUCE:
            begin
                // restoring remainder, one power-of-two multiple of 2pi per cycle
                if (red_mag_reg >= red_sub)
                    red_mag_next = red_mag_reg - red_sub;
                if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            CS_SIGN:
            begin
                z_next = red_neg_reg ? -$signed(TRIG_W'(red_mag_reg))
                                     :  $signed(TRIG_W'(red_mag_reg));
            end
            CS_WRAP:
            begin
                if (z_reg > PI_Z)
                    z_next = z_reg - TWO_PI_Z;
                else if (z_reg <= -PI_Z)
                    z_next = z_reg + TWO_PI_Z;
            end
            CS_HALF:
            begin
                qneg_next = 1'b0;
                if (z_reg > HALF_PI_Z)
                begin
                    z_next    = z_reg - PI_Z;
                    qneg_next = 1'b1;
                end
                else if (z_reg < -HALF_PI_Z)
                begin
                    z_next    = z_reg + PI_Z;
                    qneg_next = 1'b1;
                end
                x_next    = GAIN_Z;
                y_next    = '0;
                step_next = '0;
            end
            CS_ROTATE:
            begin
                if (!z_reg[TRIG_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_q30(step_reg);
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_q30(step_reg);
                end
                step_next = step_reg + 1'b1;
            end
            CS_OUT:
            begin
                cos_next  = qneg_reg ? -x_reg : x_reg;
                sin_next  = qneg_reg ? -y_reg : y_reg;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg   <= CS_IDLE;
            done_reg <= 1'b0;
            k_reg    <= '0;
            step_reg <= '0;
        end
        else
        begin
            cs_reg   <= cs_next;
            done_reg <= done_next;
            k_reg    <= k_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_mag_reg <= red_mag_next;
        red_neg_reg <= red_neg_next;
        qneg_reg    <= qneg_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
    end

    assign trig.done  = done_reg;
    assign trig.cos_v = cos_reg;
    assign trig.sin_v = sin_reg;

endmodule

>>> rtl/core/wheel_odometry_dead_reckoning_top.sv
`timescale 1ns / 1ps
// ============================================================================
// wheel_odometry_dead_reckoning_top
// Dead-reckoning pose tracker for a differential-drive base.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one sample per transfer.
//   func = FUNC_HEADING: yaw sets the heading (first yaw latched as reference),
//   and the sample goes straight to the finish step and the output register.
//   func = FUNC_ENCODER: absolute wheel counts; the block forms the count
//   deltas, the travelled distance, and moves x/y along the heading. The
//   sin/cos unit works out the heading's sin and cos, then the shared 34x16
//   multiplier builds both displacements. One sample is in work at a
//   time; in_stall is high while busy.
//   Output channel (out_valid / out_stall) presents pos_x, pos_y, heading
//   from an output register. A stalled result holds; the block still takes
//   the next sample and only waits at the end of its work if the previous
//   result has not been taken.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect in the next cycle;
//   start_x / start_y also load the position at once.
//   Reset (rst_n, asynchronous) restores register defaults and the pose.
// ============================================================================
module wheel_odometry_dead_reckoning_top
    import wdr_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic signed [19:0] yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [19:0] heading,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // pi in angle units, rounded
    localparam longint PI_QA_L = (PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                                 >>> (30 - ANGLE_FRAC_BITS);
    localparam logic signed [21:0] PI_QA     = 22'(PI_QA_L);
    localparam logic signed [21:0] TWO_PI_QA = 22'(2 * PI_QA_L);

    localparam int ACC_W  = 88;
    localparam int DIST_W = 56;
    localparam int D_SPLIT = 28;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << 37;
    localparam logic [5:0] SH_NONE = 6'd0;
    localparam logic [5:0] SH_C_HI = 6'd16;
    localparam logic [5:0] SH_D_HI = 6'd28;
    localparam logic [5:0] SH_BOTH = 6'd44;
    localparam logic [1:0] DIST_LAST = 2'd1;
    localparam logic [1:0] DISP_LAST = 2'd3;

    wdr_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    logic        [31:0] mpc_reg, mpc_next;
    logic signed [19:0] offset_reg, offset_next;
    logic signed [31:0] start_x_reg, start_x_next;
    logic signed [31:0] start_y_reg, start_y_next;
    logic        [31:0] x_pos_reg, x_pos_next;
    logic        [31:0] y_pos_reg, y_pos_next;
    logic signed [19:0] heading_reg, heading_next;
    logic signed [31:0] prev_left_reg, prev_left_next;
    logic signed [31:0] prev_right_reg, prev_right_next;
    logic signed [19:0] yaw_ref_reg, yaw_ref_next;
    logic               first_pending_reg, first_pending_next;

    logic signed [32:0] dl_reg, dl_next;
    logic signed [32:0] dr_reg, dr_next;
    logic [33:0]        mag_reg, mag_next;
    logic               dist_neg_reg, dist_neg_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [19:0] heading_out_reg;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               trig_start;
    wdr_trig_t          trig;

    // shared multiplier
    logic [33:0]        mul_a;
    logic [15:0]        mul_b;
    logic [5:0]         mul_sh;
    logic               mul_en;
    logic               acc_clear;
    logic               acc_round;
    logic [49:0]        mul_prod;
    logic [ACC_W-1:0]   mul_term;
    logic [ACC_W-1:0]   acc_base;

    logic [TRIG_W-1:0]  trig_abs;
    logic signed [TRIG_W-1:0] trig_sel;
    logic [31:0]        c_mag;
    logic [33:0]        d_lo, d_hi;
    logic [31:0]        disp_v;
    logic [31:0]        disp_signed;
    logic               disp_neg;
    logic signed [33:0] sum34;
    logic signed [21:0] th22;
    logic signed [19:0] yaw_ref_eff;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    wdr_sincos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_sincos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .theta (heading_reg),
        .trig  (trig)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = (func == FUNC_ENCODER) ? S_SUM : S_FINISH;
            end
            S_SUM:    state_next = S_DIST;
            S_DIST:   if (cnt_reg == DIST_LAST) state_next = S_WAIT;
            S_WAIT:   if (trig.done) state_next = S_DISP_X;
            S_DISP_X: if (cnt_reg == DISP_LAST) state_next = S_DISP_Y;
            S_DISP_Y: if (cnt_reg == DISP_LAST) state_next = S_UPD_Y;
            S_UPD_Y:  state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (handshake, multiplier operand steering)
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        trig_start = (state_reg == S_IDLE) && in_valid && (func == FUNC_ENCODER);
        out_load   = (state_reg == S_FINISH) && out_free;
        cnt_next   = '0;
        mul_en     = 1'b0;
        acc_clear  = 1'b0;
        acc_round  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_sh     = SH_NONE;

        trig_sel = (state_reg == S_DISP_Y) ? trig.sin_v : trig.cos_v;
        trig_abs = trig_sel[TRIG_W-1] ? TRIG_W'(-trig_sel) : TRIG_W'(trig_sel);
        c_mag    = trig_abs[31:0];
        d_lo     = {6'b0, dist_reg[D_SPLIT-1:0]};
        d_hi     = {6'b0, dist_reg[DIST_W-1:D_SPLIT]};

        case (state_reg)
            S_DIST:
            begin
                // distance = |sum| * metres_per_count, two 16-bit halves
                mul_en    = 1'b1;
                acc_clear = (cnt_reg == '0);
                mul_a     = mag_reg;
                mul_b     = (cnt_reg == '0) ? mpc_reg[15:0] : mpc_reg[31:16];
                mul_sh    = (cnt_reg == '0) ? SH_NONE : SH_C_HI;
                cnt_next  = (cnt_reg == DIST_LAST) ? 2'd0 : cnt_reg + 2'd1;
            end
            S_DISP_X, S_DISP_Y:
            begin
                // four partial products of distance times |trig|
                mul_en    = 1'b1;
                acc_clear = (cnt_reg == '0);
                acc_round = 1'b1;
                case (cnt_reg)
                    2'd0:
                    begin
                        mul_a  = d_lo;
                        mul_b  = c_mag[15:0];
                        mul_sh = SH_NONE;
                    end
                    2'd1:
                    begin
                        mul_a  = d_lo;
                        mul_b  = c_mag[31:16];
                        mul_sh = SH_C_HI;
                    end
                    2'd2:
                    begin
                        mul_a  = d_hi;
                        mul_b  = c_mag[15:0];
                        mul_sh = SH_D_HI;
                    end
                    default:
                    begin
                        mul_a  = d_hi;
                        mul_b  = c_mag[31:16];
                        mul_sh = SH_BOTH;
                    end
                endcase
                cnt_next = (cnt_reg == DISP_LAST) ? 2'd0 : cnt_reg + 2'd1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign mul_term = ACC_W'(mul_prod) << mul_sh;
    assign acc_base = acc_clear ? (acc_round ? ROUND_BIAS : '0) : acc_reg;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        mpc_next           = mpc_reg;
        offset_next        = offset_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        x_pos_next         = x_pos_reg;
        y_pos_next         = y_pos_reg;
        heading_next       = heading_reg;
        prev_left_next     = prev_left_reg;
        prev_right_next    = prev_right_reg;
        yaw_ref_next       = yaw_ref_reg;
        first_pending_next = first_pending_reg;
        dl_next            = dl_reg;
        dr_next            = dr_reg;
        mag_next           = mag_reg;
        dist_neg_next      = dist_neg_reg;
        dist_next          = dist_reg;
        acc_next           = mul_en ? acc_base + mul_term : acc_reg;

        sum34       = 34'(dl_reg) + 34'(dr_reg);
        disp_v      = acc_reg[69:38];
        disp_neg    = dist_neg_reg ^ ((state_reg == S_UPD_Y) ? trig.sin_v[TRIG_W-1]
                                                             : trig.cos_v[TRIG_W-1]);
        disp_signed = disp_neg ? 32'd0 - disp_v : disp_v;
        th22        = 22'(heading_reg);
        yaw_ref_eff = first_pending_reg ? yaw : yaw_ref_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && func == FUNC_ENCODER)
                begin
                    dl_next         = 33'(left_count) - 33'(prev_left_reg);
                    dr_next         = 33'(right_count) - 33'(prev_right_reg);
                    prev_left_next  = left_count;
                    prev_right_next = right_count;
                end
                else if (in_xfer)
                begin
                    // first heading sample becomes the yaw reference
                    if (first_pending_reg)
                    begin
                        yaw_ref_next       = yaw;
                        first_pending_next = 1'b0;
                    end
                    heading_next = yaw - yaw_ref_eff + offset_reg;
                end
            end
            S_SUM:
            begin
                mag_next      = sum34[33] ? 34'(-sum34) : 34'(sum34);
                dist_neg_next = sum34[33];
            end
            S_WAIT:
            begin
                dist_next = acc_reg[64:9];
            end
            S_DISP_Y:
            begin
                // x product finished on the previous edge
                if (cnt_reg == '0)
                    x_pos_next = x_pos_reg + disp_signed;
            end
            S_UPD_Y:
            begin
                y_pos_next = y_pos_reg + disp_signed;
                // wrap heading once into (-pi, pi]
                if (th22 > PI_QA)
                    heading_next = 20'(th22 - TWO_PI_QA);
                else if (th22 <= -PI_QA)
                    heading_next = 20'(th22 + TWO_PI_QA);
            end
            default:
            begin
                dist_next = dist_reg;
            end
        endcase

        if (cfg_we)
        begin
            case (wdr_reg_idx_t'(cfg_index))
                REG_MPC:     mpc_next = cfg_data;
                REG_OFFSET:  offset_next = cfg_data[19:0];
                REG_START_X:
                begin
                    start_x_next = cfg_data;
                    x_pos_next   = cfg_data;
                end
                REG_START_Y:
                begin
                    start_y_next = cfg_data;
                    y_pos_next   = cfg_data;
                end
                default:     mpc_next = mpc_reg;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            mpc_reg           <= MPC_RESET;
            offset_reg        <= OFFSET_RESET;
            start_x_reg       <= START_X_RESET;
            start_y_reg       <= START_Y_RESET;
            x_pos_reg         <= START_X_RESET;
            y_pos_reg         <= START_Y_RESET;
            heading_reg       <= HEADING_RESET;
            prev_left_reg     <= '0;
            prev_right_reg    <= '0;
            yaw_ref_reg       <= '0;
            first_pending_reg <= 1'b1;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            out_valid_reg     <= out_valid_next;
            mpc_reg           <= mpc_next;
            offset_reg        <= offset_next;
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            x_pos_reg         <= x_pos_next;
            y_pos_reg         <= y_pos_next;
            heading_reg       <= heading_next;
            prev_left_reg     <= prev_left_next;
            prev_right_reg    <= prev_right_next;
            yaw_ref_reg       <= yaw_ref_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        dl_reg       <= dl_next;
        dr_reg       <= dr_next;
        mag_reg      <= mag_next;
        dist_neg_reg <= dist_neg_next;
        dist_reg     <= dist_next;
        acc_reg      <= acc_next;
        if (out_load)
        begin
            pos_x_reg       <= x_pos_reg;
            pos_y_reg       <= y_pos_reg;
            heading_out_reg <= heading_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result presented outside the finish step");

    a_heading_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == FUNC_HEADING |=> $stable(prev_left_reg) && $stable(prev_right_reg))
        else $error("heading transfer changed stored wheel counts");

    a_reference_latched_once: assert property (@(posedge clk) disable iff (!rst_n)
        !first_pending_reg |=> !first_pending_reg)
        else $error("yaw reference re-armed");

    a_trig_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        trig.done |-> state_reg == S_WAIT)
        else $error("sin/cos result arrived while sequencer not waiting");

endmodule
